// File: rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

    // Deepest window the cell row can hold, and the sample width.
    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;

    // Width of the window size register and of the fill counter.
    localparam int WIN_BITS = 5;

    // Window size after reset.
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(3);

    // One candidate slot of the row: a sample and whether it may still be a maximum.
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] value;
    } cand_t;

    // Control that the top level hands to every cell of the row.
    typedef struct packed {
        logic                          advance;
        logic                          clear;
        logic                          keep;
        logic signed [SAMPLE_BITS-1:0] sample;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/swm_cell.sv
`default_nettype none

module swm_cell (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire swm_pkg::cell_ctrl_t ctrl,
    input  wire swm_pkg::cand_t    prev,
    output swm_pkg::cand_t         cand_q,
    output swm_pkg::cand_t         cand_d
);
    import swm_pkg::*;

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;

    // Take the neighbor's candidate one step older. It survives unless the
    // stream restarts, it falls out of the window, or the new word beats it.
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.advance) begin
            value_next = prev.value;
            valid_next = prev.valid && !ctrl.clear && ctrl.keep &&
                         !(prev.value < ctrl.sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // The value needs no reset; it is only read while its valid bit is set.
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign cand_q = '{valid: valid_reg, value: value_reg};
    assign cand_d = '{valid: valid_next, value: value_next};

endmodule

`default_nettype wire

// File: rtl/swm_front_sel.sv
`default_nettype none

module swm_front_sel (
    input  wire swm_pkg::cand_t                            cands [swm_pkg::MAX_WINDOW],
    output logic signed [swm_pkg::SAMPLE_BITS-1:0]         front_value
);
    import swm_pkg::*;

    // The oldest surviving candidate is the window maximum: survivors never
    // rise in value from oldest to newest. Later (older) hits take priority.
    always_comb begin
        front_value = cands[0].value;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (cands[i].valid) begin
                front_value = cands[i].value;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sliding_window_max_unit.sv
`default_nettype none

// Sliding window maximum. Each accepted word carries one signed 16-bit sample
// and a start flag in tuser that restarts the stream before the sample is
// taken. Once window_size samples have arrived since reset or the last start,
// every word yields one result word: the largest of the last window_size
// samples, the new one included; before that, words yield nothing. Window
// sizes of zero act as 1 and sizes above 16 act as 16. The samples sit in a
// row of 16 cells that shifts by one on each accepted word; each cell drops
// its sample once it leaves the window or a newer, strictly larger sample
// arrives. The block takes one word per cycle and puts the result in an output
// register in the cycle after acceptance; it stalls only while that register
// holds a result that the sink has not taken. There is no clearing pass after
// reset. Write cfg_wr_data only between streams or while no word is in flight.
module sliding_window_max_unit (
    input  wire         aclk,
    input  wire         aresetn,

    // Configuration: window size.
    input  wire         cfg_wr_en,
    input  wire  [4:0]  cfg_wr_data,

    // Input words.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    input  wire  [0:0]  s_tuser,   // [0] start_req

    // Result words.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata    // [15:0] window_max
);
    import swm_pkg::*;

    logic [WIN_BITS-1:0]           window_size_reg;
    logic [WIN_BITS-1:0]           win_eff;
    logic [WIN_BITS-1:0]           seen_count_reg;
    logic [WIN_BITS-1:0]           seen_count_next;
    logic [WIN_BITS-1:0]           seen_base;
    logic [WIN_BITS-1:0]           seen_inc;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [15:0]                   m_tdata_reg;
    logic                          s_accept;
    logic                          start_req;
    logic                          has_result;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] front_value;

    cell_ctrl_t ctrl [MAX_WINDOW];
    cand_t      prev [MAX_WINDOW];
    cand_t      cand_q [MAX_WINDOW];
    cand_t      cand_d [MAX_WINDOW];

    assign sample    = s_tdata[SAMPLE_BITS-1:0];
    assign start_req = s_tuser[0];
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;

    // Window size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_RESET;
        end else if (cfg_wr_en) begin
            window_size_reg <= cfg_wr_data;
        end
    end

    // Clamp the window size to what the row can hold.
    always_comb begin
        win_eff = window_size_reg;
        if (window_size_reg == '0) begin
            win_eff = WIN_BITS'(1);
        end else if (window_size_reg > WIN_BITS'(MAX_WINDOW)) begin
            win_eff = WIN_BITS'(MAX_WINDOW);
        end
    end

    // Per-cell control and the neighbor chain; cell 0 takes the new sample.
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            ctrl[i].advance = s_accept;
            ctrl[i].clear   = (i != 0) && start_req;
            ctrl[i].keep    = (WIN_BITS'(i) < win_eff);
            ctrl[i].sample  = sample;
            if (i == 0) begin
                prev[i] = '{valid: 1'b1, value: sample};
            end else begin
                prev[i] = cand_q[i-1];
            end
        end
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl[g]),
            .prev    (prev[g]),
            .cand_q  (cand_q[g]),
            .cand_d  (cand_d[g])
        );
    end

    swm_front_sel u_front_sel (
        .cands       (cand_d),
        .front_value (front_value)
    );

    // Count of samples seen, saturating at the window size.
    always_comb begin
        seen_base = start_req ? '0 : seen_count_reg;
        seen_inc  = seen_base + WIN_BITS'(1);
        seen_count_next = seen_count_reg;
        if (s_accept) begin
            seen_count_next = (seen_inc > win_eff) ? win_eff : seen_inc;
        end
    end

    assign has_result = (seen_count_next >= win_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_count_reg <= '0;
        end else begin
            seen_count_reg <= seen_count_next;
        end
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (s_accept && has_result) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && has_result) begin
            m_tdata_reg <= 16'(front_value);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    // The newest sample always survives its own step.
    a_newest_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> cand_q[0].valid)
        else $error("newest cell not valid after accept");

    // The fill count never passes the deepest window.
    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_count_reg <= WIN_BITS'(MAX_WINDOW))
        else $error("fill count beyond window depth");

    // A new result only follows an accepted word.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s_accept))
        else $error("result without accepted word");

    // A fresh start with a window of one yields a result at once.
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && start_req && win_eff == WIN_BITS'(1)) |=> m_tvalid_reg)
        else $error("missing result after start with window of one");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int AGE_CAP      = 31;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_WORDS  = 58;

    // Clock, reset and block ports; every input starts at a known value.
    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [WIN_BITS-1:0]    cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata     = '0;
    logic [0:0]             s_tuser     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [15:0]            m_tdata;

    // Shadow of the window register and the candidate queue.
    logic [WIN_BITS-1:0]            win_reg = WIN_RESET;
    logic signed [SAMPLE_BITS-1:0]  cand_val [MAX_WINDOW];
    int                             cand_age [MAX_WINDOW];
    int                             cand_cnt = 0;
    int                             seen_cnt = 0;

    // Window maxima still owed by the block, oldest first.
    logic signed [SAMPLE_BITS-1:0]  max_expect_q [$];

    int                             err_cnt      = 0;
    int                             src_idle_pct = 0;
    int                             snk_idle_pct = 0;
    int                             hold_left    = 0;
    int                             cycle_cnt    = 0;
    logic signed [SAMPLE_BITS-1:0]  ramp_val     = '0;

    sliding_window_max_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // [15:0] sample
        .s_tuser     (s_tuser),     // [0] start_req
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // [15:0] window_max
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the candidate queue by one sample and queue the maximum once the
    // window is full.
    function automatic void track_window(input logic signed [SAMPLE_BITS-1:0] smp,
                                         input logic start);
        int w;
        int drop;
        w = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
        if (start) begin
            cand_cnt = 0;
            seen_cnt = 0;
        end
        for (int i = 0; i < cand_cnt; i++) begin
            if (cand_age[i] < AGE_CAP) begin
                cand_age[i]++;
            end
        end
        // Oldest candidates that have left the window go first.
        drop = 0;
        while (drop < cand_cnt && cand_age[drop] >= w) begin
            drop++;
        end
        if (drop > 0) begin
            for (int i = 0; i + drop < cand_cnt; i++) begin
                cand_val[i] = cand_val[i + drop];
                cand_age[i] = cand_age[i + drop];
            end
            cand_cnt -= drop;
        end
        // Strictly smaller newer candidates can never be a maximum again.
        while (cand_cnt > 0 && cand_val[cand_cnt - 1] < smp) begin
            cand_cnt--;
        end
        if (cand_cnt < MAX_WINDOW) begin
            cand_val[cand_cnt] = smp;
            cand_age[cand_cnt] = 0;
            cand_cnt++;
        end
        seen_cnt++;
        if (seen_cnt > w) begin
            seen_cnt = w;
        end
        if (seen_cnt >= w) begin
            max_expect_q = {max_expect_q, cand_val[0]};
        end
    endfunction

    // Mix of full-range noise, a narrow band that produces ties, and ramps
    // that build a deep candidate queue.
    function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return SAMPLE_BITS'($urandom);
        end else if (r < 70) begin
            return SAMPLE_BITS'($urandom_range(6)) - 16'sd3;
        end else if (r < 85) begin
            ramp_val = ramp_val - SAMPLE_BITS'($urandom_range(1, 100));
        end else begin
            ramp_val = ramp_val + SAMPLE_BITS'($urandom_range(1, 100));
        end
        return ramp_val;
    endfunction

    // Offer one word after a random gap and wait until it is taken.
    task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        track_window(smp, start);
    endtask

    // Stop offering words and wait until every owed maximum has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (max_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_BITS-1:0] size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        win_reg      = size;
        @(posedge aclk);
    endtask

    // Reset window of three: sample extremes and ties that must be kept.
    task automatic test_default_window();
        logic signed [SAMPLE_BITS-1:0] pat [10];
        pat = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
                16'sd7, 16'sd7, 16'sd2, 16'sd7, -16'sd32768};
        foreach (pat[i]) begin
            send_word(pat[i], i == 0);
        end
        wait_drained();
    endtask

    // Size zero acts as one, sizes above sixteen act as sixteen, and a size
    // change or a start in the middle of a stream.
    task automatic test_window_limits();
        write_window(5'd0);
        send_word(16'sd100, 1'b0);
        send_word(-16'sd100, 1'b0);
        send_word(16'sd0, 1'b0);
        wait_drained();
        write_window(5'd31);
        send_word(16'sd5, 1'b0);
        send_word(16'sd9, 1'b0);
        send_word(-16'sd3, 1'b0);
        send_word(16'sd9, 1'b0);
        wait_drained();
        write_window(5'd2);
        send_word(-16'sd7, 1'b0);
        send_word(16'sd4, 1'b1);
        send_word(-16'sd2, 1'b0);
        wait_drained();
        write_window(5'd17);
        send_word(16'sd32767, 1'b1);
        wait_drained();
    endtask

    // Several window settings under one idling profile, each followed by a
    // run of random words.
    task automatic test_random_phase(input int src_pct, input int snk_pct);
        logic [WIN_BITS-1:0] size;
        logic                start;
        wait_drained();
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(9))
                0: begin size = 5'd0; end
                1: begin size = 5'd1; end
                2: begin size = 5'd16; end
                3: begin size = 5'd31; end
                4: begin size = 5'd17; end
                default: begin size = WIN_BITS'($urandom_range(1, 16)); end
            endcase
            write_window(size);
            for (int j = 0; j < PHASE_WORDS; j++) begin
                start = (j == 0 && $urandom_range(1) == 1) || $urandom_range(49) == 0;
                send_word(next_sample(), start);
            end
            wait_drained();
        end
    endtask

    // The sink holds off for a long stretch while words keep coming, so the
    // output register fills and the input stalls.
    task automatic test_output_hold();
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_window(5'd4);
        hold_left = 80;
        for (int j = 0; j < 30; j++) begin
            send_word(next_sample(), j == 0);
        end
        wait_drained();
    endtask

    // Sink side: random back-pressure, and each taken word compared with the
    // oldest owed maximum.
    always @(posedge aclk) begin : result_check
        logic signed [SAMPLE_BITS-1:0] exp_max;
        if (m_tvalid && m_tready) begin
            if (max_expect_q.size() == 0) begin
                $error("window_max: got %0d with no result owed", $signed(m_tdata));
                err_cnt++;
            end else begin
                exp_max = max_expect_q[0];
                max_expect_q.delete(0);
                if (m_tdata !== exp_max) begin
                    $error("window_max: expected %0d, got %0d", exp_max, $signed(m_tdata));
                    err_cnt++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 11;
        snk_idle_pct = 59;
        test_default_window();
        test_window_limits();
        test_random_phase(11, 59);
        test_random_phase(59, 11);
        test_output_hold();
        test_random_phase(0, 0);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (max_expect_q.size() != 0) begin
            $error("window_max: %0d results never arrived", max_expect_q.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
